// File: hw/rtl/iocg_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the in-order completion gate
// depends on nothing; used by iocg_slot_ram and in_order_completion_gate
package iocg_pkg;

  // default geometry
  localparam int WINDOW_DEFAULT        = 32;
  localparam int PAYLOAD_WIDTH_DEFAULT = 16;

  // fixed field widths of the stream ports
  localparam int SEQ_W      = 32;
  localparam int PAY_PORT_W = 16;
  localparam int STATUS_W   = 2;

  // request kind carried in tuser
  localparam logic KIND_COMPLETION = 1'b0;
  localparam logic KIND_SKIP       = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_IN_ORDER = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LATE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd2;

  // control sequencer
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

// File: hw/rtl/iocg_slot_ram.sv
`timescale 1ns / 1ps
// payload store of the reorder window: one write port, one registered read port
// depends on iocg_pkg for default sizes
module iocg_slot_ram #(
  parameter int DEPTH = iocg_pkg::WINDOW_DEFAULT,
  parameter int WIDTH = iocg_pkg::PAYLOAD_WIDTH_DEFAULT,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/in_order_completion_gate.sv
`timescale 1ns / 1ps
// in_order_completion_gate: releases completions in sequence order.
// A late or rejected completion passes through the hold stage and then the output register.
// An in-order release drains one window slot per cycle from the payload ram while the output
// is not stalled; each stored slot drained gives a result, each skipped slot gives none.
// Reset: next due number to zero, pending and skip marks cleared at once; no clearing pass.
// depends on iocg_pkg and iocg_slot_ram
module in_order_completion_gate #(
  parameter int WINDOW        = iocg_pkg::WINDOW_DEFAULT,
  parameter int PAYLOAD_WIDTH = iocg_pkg::PAYLOAD_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // seq[31:0], payload[47:32]
  input  logic        s_axis_tuser,   // kind
  // result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_seq[31:0], out_payload[47:32]
  output logic [1:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast    // last
);

  localparam int SW = $clog2(WINDOW);
  localparam int QW = iocg_pkg::SEQ_W;
  localparam int PW = iocg_pkg::PAY_PORT_W;
  localparam int TW = iocg_pkg::STATUS_W;

  iocg_pkg::state_t state;

  logic [QW-1:0]     next_due;
  logic [SW-1:0]     head;
  logic [WINDOW-1:0] pending;
  logic [WINDOW-1:0] skipm;

  // result waiting to learn whether another one follows
  logic              hold_valid;
  logic [QW-1:0]     hold_seq;
  logic [PW-1:0]     hold_pay;
  logic [TW-1:0]     hold_status;

  // output register
  logic [QW-1:0]     out_seq;
  logic [PW-1:0]     out_payload;
  logic [TW-1:0]     out_status;
  logic              out_last;

  logic [QW-1:0]            in_seq;
  logic [PW-1:0]            in_pay;
  logic                     accept;
  logic                     is_skip;
  logic                     late;
  logic                     in_window;
  logic [QW-1:0]            offset;
  logic [SW:0]              slot_sum;
  logic [SW-1:0]            slot;
  logic [SW-1:0]            head_inc;
  logic [PAYLOAD_WIDTH+PW-1:0] pay_in_ext;
  logic [PAYLOAD_WIDTH-1:0] pay_store;
  logic [PAYLOAD_WIDTH+PW-1:0] pay_store_ext;
  logic [PW-1:0]            pay_kept;
  logic [PAYLOAD_WIDTH-1:0] ram_rd;
  logic [PAYLOAD_WIDTH+PW-1:0] ram_rd_ext;
  logic [PW-1:0]            ram_pay;
  logic                     wr_en;
  logic                     rd_en;
  logic                     out_free;
  logic                     head_pend;
  logic                     head_skip;

  // request fields
  assign in_seq  = s_axis_tdata[QW-1:0];
  assign in_pay  = s_axis_tdata[QW+PW-1:QW];
  assign is_skip = (s_axis_tuser == iocg_pkg::KIND_SKIP);

  assign s_axis_tready = (state == iocg_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // payload kept to the stored width, then shown at port width
  assign pay_in_ext    = {{PAYLOAD_WIDTH{1'b0}}, in_pay};
  assign pay_store     = pay_in_ext[PAYLOAD_WIDTH-1:0];
  assign pay_store_ext = {{PW{1'b0}}, pay_store};
  assign pay_kept      = pay_store_ext[PW-1:0];
  assign ram_rd_ext    = {{PW{1'b0}}, ram_rd};
  assign ram_pay       = ram_rd_ext[PW-1:0];

  // window classification and slot of the incoming number
  always_comb begin
    late      = in_seq < next_due;
    offset    = in_seq - next_due;
    in_window = !late && (offset < QW'(WINDOW));
    slot_sum  = {1'b0, head} + {1'b0, offset[SW-1:0]};
    if (slot_sum >= (SW+1)'(WINDOW)) begin
      slot_sum = slot_sum - (SW+1)'(WINDOW);
    end
    slot = slot_sum[SW-1:0];
  end

  // slot following the head; a wrap of the sequence number restarts at slot zero
  always_comb begin
    if (next_due == '1 || head == SW'(WINDOW - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head + 1'b1;
    end
  end

  assign head_pend = pending[head];
  assign head_skip = skipm[head];

  assign wr_en = accept && !is_skip && in_window && !pending[slot];
  assign rd_en = (state == iocg_pkg::S_SCAN) && head_pend && (!hold_valid || out_free);

  iocg_slot_ram #(
    .DEPTH (WINDOW),
    .WIDTH (PAYLOAD_WIDTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (pay_store),
    .rd_en   (rd_en),
    .rd_addr (head),
    .rd_data (ram_rd)
  );

  // sequencer, window marks and due number
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= iocg_pkg::S_IDLE;
      next_due   <= '0;
      head       <= '0;
      pending    <= '0;
      skipm      <= '0;
      hold_valid <= 1'b0;
    end else begin
      case (state)
        iocg_pkg::S_IDLE: begin
          if (accept) begin
            if (is_skip) begin
              if (in_window) begin
                skipm[slot] <= 1'b1;
                state       <= iocg_pkg::S_SCAN;
              end
            end else if (late || !in_window) begin
              hold_valid <= 1'b1;
              state      <= iocg_pkg::S_SCAN;
            end else if (!pending[slot]) begin
              pending[slot] <= 1'b1;
              state         <= iocg_pkg::S_SCAN;
            end
          end
        end
        iocg_pkg::S_SCAN: begin
          if (head_pend) begin
            if (!hold_valid || out_free) begin
              hold_valid    <= 1'b1;
              pending[head] <= 1'b0;
              skipm[head]   <= 1'b0;
              next_due      <= next_due + 1'b1;
              head          <= head_inc;
            end
          end else if (head_skip) begin
            skipm[head] <= 1'b0;
            next_due    <= next_due + 1'b1;
            head        <= head_inc;
          end else if (!hold_valid) begin
            state <= iocg_pkg::S_IDLE;
          end else if (out_free) begin
            hold_valid <= 1'b0;
            state      <= iocg_pkg::S_IDLE;
          end
        end
        default: begin
          state <= iocg_pkg::S_IDLE;
        end
      endcase
    end
  end

  // held result contents
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_seq    <= in_seq;
      hold_status <= late ? iocg_pkg::ST_LATE : iocg_pkg::ST_REJECT;
      hold_pay    <= late ? pay_kept : '0;
    end else if (rd_en) begin
      hold_seq    <= next_due;
      hold_status <= iocg_pkg::ST_IN_ORDER;
    end
  end

  // output register: a held result moves out when the next one is found or the drain ends
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == iocg_pkg::S_SCAN && hold_valid && out_free
                 && (head_pend || !head_skip)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == iocg_pkg::S_SCAN && hold_valid && out_free
        && (head_pend || !head_skip)) begin
      out_seq     <= hold_seq;
      out_status  <= hold_status;
      out_payload <= (hold_status == iocg_pkg::ST_IN_ORDER) ? ram_pay : hold_pay;
      out_last    <= !head_pend;
    end
  end

  assign m_axis_tdata = {out_payload, out_seq};
  assign m_axis_tuser = out_status;
  assign m_axis_tlast = out_last;

`ifndef SYNTHESIS
  // the slot at the due number is always a gap once a drain has finished
  a_idle_head_gap: assert property (@(posedge clk) disable iff (rst)
    state == iocg_pkg::S_IDLE |-> !(pending[head] || skipm[head]))
    else $error("head slot still marked while idle");

  // nothing is left waiting in the hold stage between requests
  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    state == iocg_pkg::S_IDLE |-> !hold_valid)
    else $error("held result lost on return to idle");

  // every ram read yields an in-order result in the hold stage
  a_read_holds: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> hold_valid && hold_status == iocg_pkg::ST_IN_ORDER)
    else $error("ram read not captured as in-order result");
`endif

endmodule
